/* sv/four_level_fsk_rrc_modulator_defines.svh */
// Assertion macros shared by the modulator RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef FOUR_LEVEL_FSK_RRC_MODULATOR_DEFINES_SVH
`define FOUR_LEVEL_FSK_RRC_MODULATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset
`define FSK4RRC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be seen outside reset
`define FSK4RRC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define FSK4RRC_ASSERT(lbl, clk, rstn, prop, msg)
`define FSK4RRC_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

/* sv/fsk4rrc_pkg.sv */
// Shared types, constants and tables of the four-level FSK RRC modulator.
// No dependencies.
package fsk4rrc_pkg;

    localparam int LEVEL_W          = 16;
    localparam int SAMPLE_W         = 16;
    localparam int COEF_W           = 16;
    localparam int BYTE_W           = 8;
    localparam int DIBIT_W          = 2;
    localparam int SYMBOLS_PER_BYTE = 4;
    localparam int SYM_W            = $clog2(SYMBOLS_PER_BYTE);
    localparam int COEF_COUNT       = 90;
    localparam int COEF_IDX_W       = 8;
    localparam int QUEUE_DEPTH      = 2;

    localparam int INTERP_FACTOR_DEF  = 10;
    localparam int TAPS_PER_PHASE_DEF = 9;

    // Request kinds carried on tuser
    localparam logic REQ_DATA    = 1'b0;
    localparam logic REQ_SILENCE = 1'b1;

    // Dibit codes
    localparam logic [DIBIT_W-1:0] DIBIT_C = 2'b00;
    localparam logic [DIBIT_W-1:0] DIBIT_D = 2'b01;
    localparam logic [DIBIT_W-1:0] DIBIT_B = 2'b10;
    localparam logic [DIBIT_W-1:0] DIBIT_A = 2'b11;

    typedef logic signed [LEVEL_W-1:0]        t_level;
    typedef t_level [SYMBOLS_PER_BYTE-1:0]     t_group;
    typedef logic [COEF_IDX_W-1:0]             t_coef_idx;

    // One mapped item moving through the queue
    typedef struct packed {
        logic   valid;
        t_group levels;
    } t_grp_xfer;

    // Root-raised-cosine prototype, Q1.15
    localparam logic signed [COEF_W-1:0] COEF_TABLE [COEF_COUNT] = '{
        16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
        16'sd850, 16'sd592, 16'sd219, -16'sd234, -16'sd720, -16'sd1179,
        -16'sd1548, -16'sd1769, -16'sd1795, -16'sd1597,
        -16'sd1172, -16'sd544, 16'sd237, 16'sd1092, 16'sd1927, 16'sd2637,
        16'sd3120, 16'sd3286, 16'sd3073, 16'sd2454,
        16'sd1447, 16'sd116, -16'sd1431, -16'sd3043, -16'sd4544, -16'sd5739,
        -16'sd6442, -16'sd6483, -16'sd5735, -16'sd4121,
        -16'sd1633, 16'sd1669, 16'sd5651, 16'sd10118, 16'sd14822, 16'sd19485,
        16'sd23811, 16'sd27521, 16'sd30368, 16'sd32157,
        16'sd32767,
        16'sd32157, 16'sd30368, 16'sd27521, 16'sd23811, 16'sd19485, 16'sd14822,
        16'sd10118, 16'sd5651, 16'sd1669, -16'sd1633,
        -16'sd4121, -16'sd5735, -16'sd6483, -16'sd6442, -16'sd5739, -16'sd4544,
        -16'sd3043, -16'sd1431, 16'sd116, 16'sd1447,
        16'sd2454, 16'sd3073, 16'sd3286, 16'sd3120, 16'sd2637, 16'sd1927,
        16'sd1092, 16'sd237, -16'sd544, -16'sd1172,
        -16'sd1597, -16'sd1795, -16'sd1769, -16'sd1548, -16'sd1179, -16'sd720,
        -16'sd234, 16'sd219, 16'sd592, 16'sd850
    };

    // Coefficient lookup; indexes past the table read as zero
    function automatic logic signed [COEF_W-1:0] coef_at(input t_coef_idx idx);
        logic signed [COEF_W-1:0] c;
        c = '0;
        if (idx < t_coef_idx'(COEF_COUNT)) begin
            c = COEF_TABLE[idx[6:0]];
        end
        return c;
    endfunction

    // Map one dibit to its Q1.15 level for the selected deviation set
    function automatic t_level level_map(input logic [DIBIT_W-1:0] dibit,
                                         input logic low_dev);
        t_level lvl;
        unique case (dibit)
            DIBIT_A: lvl = low_dev ? 16'sd12419  : 16'sd24805;
            DIBIT_B: lvl = low_dev ? 16'sd4129   : 16'sd8258;
            DIBIT_C: lvl = low_dev ? -16'sd4129  : -16'sd8258;
            default: lvl = low_dev ? -16'sd12419 : -16'sd24805;
        endcase
        return lvl;
    endfunction

endpackage

/* sv/fsk4rrc_front.sv */
// Front end: accepts requests, holds the deviation register, maps dibits to levels.
// Depends on fsk4rrc_pkg.
module fsk4rrc_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_wdata,
    input  logic                       i_s_valid,
    output logic                       o_s_ready,
    input  logic                       i_s_kind,
    input  logic [7:0]                 i_s_byte,
    input  logic                       i_q_full,
    output fsk4rrc_pkg::t_grp_xfer     o_push
);
    import fsk4rrc_pkg::*;

    logic   r_low_dev;
    t_group levels;

    // Deviation select register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_dev <= 1'b0;
        end else if (i_cfg_we) begin
            r_low_dev <= i_cfg_wdata;
        end
    end

    // Split the byte MSB-first; silence gives zero levels
    always_comb begin
        for (int s = 0; s < SYMBOLS_PER_BYTE; s++) begin
            if (i_s_kind == REQ_SILENCE) begin
                levels[s] = '0;
            end else begin
                levels[s] = level_map(i_s_byte[BYTE_W-1-DIBIT_W*s -: DIBIT_W], r_low_dev);
            end
        end
    end

    // Transfer straight into the queue while it has room
    assign o_s_ready     = !i_q_full;
    assign o_push.valid  = i_s_valid && !i_q_full;
    assign o_push.levels = levels;

endmodule

/* sv/fsk4rrc_queue.sv */
// Short FIFO of mapped level groups between front and back end.
// Depends on fsk4rrc_pkg.
module fsk4rrc_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fsk4rrc_pkg::t_grp_xfer     i_push,
    output logic                       o_full,
    output fsk4rrc_pkg::t_grp_xfer     o_head,
    input  logic                       i_pop
);
    import fsk4rrc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_group             r_store [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic               do_push;
    logic               do_pop;

    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && (r_count != '0);

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Payload storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_store[r_wr_ptr] <= i_push.levels;
        end
    end

    assign o_full        = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_head.valid  = (r_count != '0);
    assign o_head.levels = r_store[r_rd_ptr];

endmodule

/* sv/fsk4rrc_filter.sv */
// Back end: symbol history and polyphase RRC interpolator, one sample per cycle while the output is not held.
// Depends on fsk4rrc_pkg and four_level_fsk_rrc_modulator_defines.svh.
module fsk4rrc_filter #(
    parameter int INTERP_FACTOR  = fsk4rrc_pkg::INTERP_FACTOR_DEF,
    parameter int TAPS_PER_PHASE = fsk4rrc_pkg::TAPS_PER_PHASE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fsk4rrc_pkg::t_grp_xfer              i_head,
    output logic                                o_pop,
    output logic                                o_m_valid,
    input  logic                                i_m_ready,
    output logic signed [fsk4rrc_pkg::SAMPLE_W-1:0] o_m_sample,
    output logic                                o_m_last
);
    import fsk4rrc_pkg::*;
    `include "four_level_fsk_rrc_modulator_defines.svh"

    localparam int L      = INTERP_FACTOR;
    localparam int T      = TAPS_PER_PHASE;
    localparam int N      = L * T;
    localparam int PH_W   = $clog2(L);
    localparam int PROD_W = 2 * LEVEL_W;
    localparam int ACC_W  = PROD_W + $clog2(T) + 1;
    localparam int NP     = (T + 1) / 2;
    localparam int Q_W    = ACC_W - 16;

    // Control state
    logic [PH_W-1:0]  r_phase, n_phase;
    logic [SYM_W-1:0] r_sym,   n_sym;
    t_level           r_hist [T];
    logic             r_v1, r_v2, r_v3, r_ov;
    logic             r_l1, r_l2, r_l3, r_ol;

    // Datapath
    logic signed [PROD_W-1:0]  r_prod [T];
    logic signed [ACC_W-1:0]   r_pair [NP];
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [SAMPLE_W-1:0] r_sample;

    logic             en;
    logic             issue;
    logic             first_phase;
    logic             phase_end;
    logic             last;
    t_level           level_new;
    t_level           view [T];
    logic signed [COEF_W-1:0] coef [T];
    logic signed [ACC_W-1:0]  pair_sum [NP];
    logic signed [ACC_W-1:0]  tree_sum;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [Q_W-1:0]    q;
    logic signed [SAMPLE_W-1:0] sat;

    // Whole pipeline advances unless the output is held
    assign en          = !r_ov || i_m_ready;
    assign issue       = i_head.valid && en;
    assign first_phase = (r_phase == '0);
    assign phase_end   = (r_phase == PH_W'(L - 1));
    assign last        = phase_end && (r_sym == SYM_W'(SYMBOLS_PER_BYTE - 1));
    assign o_pop       = issue && last;
    assign level_new   = i_head.levels[r_sym];

    // History as seen by this phase: shifted in on phase zero
    always_comb begin
        view[0] = first_phase ? level_new : r_hist[0];
        for (int k = 1; k < T; k++) begin
            view[k] = first_phase ? r_hist[k-1] : r_hist[k];
        end
    end

    // Phase and symbol sequencing
    always_comb begin
        n_phase = r_phase;
        n_sym   = r_sym;
        if (issue) begin
            if (phase_end) begin
                n_phase = '0;
                n_sym   = (r_sym == SYM_W'(SYMBOLS_PER_BYTE - 1)) ? '0 : r_sym + 1'b1;
            end else begin
                n_phase = r_phase + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_sym   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_ov    <= 1'b0;
            r_l1    <= 1'b0;
            r_l2    <= 1'b0;
            r_l3    <= 1'b0;
            r_ol    <= 1'b0;
            for (int k = 0; k < T; k++) begin
                r_hist[k] <= '0;
            end
        end else begin
            r_phase <= n_phase;
            r_sym   <= n_sym;
            if (issue && first_phase) begin
                for (int k = 0; k < T; k++) begin
                    r_hist[k] <= view[k];
                end
            end
            if (en) begin
                r_v1 <= issue;
                r_l1 <= last;
                r_v2 <= r_v1;
                r_l2 <= r_l1;
                r_v3 <= r_v2;
                r_l3 <= r_l2;
                r_ov <= r_v3;
                r_ol <= r_l3;
            end
        end
    end

    // Coefficient per tap for the current phase
    for (genvar k = 0; k < T; k++) begin : g_coef
        assign coef[k] = coef_at(t_coef_idx'(N - 1 - k * L) - t_coef_idx'(r_phase));
    end

    // Pairwise adds of the products
    for (genvar p = 0; p < NP; p++) begin : g_pair
        if (2 * p + 1 < T) begin : g_two
            assign pair_sum[p] = ACC_W'(r_prod[2*p]) + ACC_W'(r_prod[2*p+1]);
        end else begin : g_one
            assign pair_sum[p] = ACC_W'(r_prod[2*p]);
        end
    end

    // Final sum of the pairs
    always_comb begin
        tree_sum = '0;
        for (int p = 0; p < NP; p++) begin
            tree_sum = tree_sum + r_pair[p];
        end
    end

    // Round half up to Q2.14, then saturate
    always_comb begin
        rnd = r_acc + ACC_W'(32768);
        q   = rnd[ACC_W-1:16];
        if (q > Q_W'(32767)) begin
            sat = 16'sh7FFF;
        end else if (q < -Q_W'(32768)) begin
            sat = 16'sh8000;
        end else begin
            sat = q[SAMPLE_W-1:0];
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < T; k++) begin
                r_prod[k] <= view[k] * coef[k];
            end
            for (int p = 0; p < NP; p++) begin
                r_pair[p] <= pair_sum[p];
            end
            r_acc    <= tree_sum;
            r_sample <= sat;
        end
    end

    assign o_m_valid  = r_ov;
    assign o_m_sample = r_sample;
    assign o_m_last   = r_ol;

    `FSK4RRC_ASSERT(a_pop_needs_head, i_clk, i_rst_n, o_pop |-> i_head.valid, "pop from empty queue")
    `FSK4RRC_ASSERT_NEVER(a_phase_range, i_clk, i_rst_n, r_phase > PH_W'(L - 1), "phase out of range")
    `FSK4RRC_ASSERT(a_stall_freezes, i_clk, i_rst_n, (r_ov && !i_m_ready) |=> $stable(r_v1) && $stable(r_phase) && $stable(r_sym), "pipeline moved during output stall")
    `FSK4RRC_ASSERT(a_phase_wraps, i_clk, i_rst_n, (issue && phase_end) |=> (r_phase == '0), "phase did not wrap after last phase")

endmodule

/* sv/four_level_fsk_rrc_modulator.sv */
// Top level of the four-level FSK modulator with RRC polyphase interpolation.
// Depends on fsk4rrc_pkg, fsk4rrc_front, fsk4rrc_queue and fsk4rrc_filter.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tuser: req_type; tdata: data_byte
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: sample; tlast: last_sample
//  cfg       in         i_cfg_we                     i_cfg_wdata: low_deviation
//
// Each request yields 4 x INTERP_FACTOR samples (40 by default), one per cycle while the output
// is not stalled, a rate set by the single sample-issue slot of the filter.
// A request passes the queue, then the multiply, pair-add, final-add and round registers to its first sample.
// A two-entry queue takes further requests while the filter is busy.
// An output stall freezes the whole filter pipeline; reset is synchronous, active low.
module four_level_fsk_rrc_modulator #(
    parameter int INTERP_FACTOR  = fsk4rrc_pkg::INTERP_FACTOR_DEF,
    parameter int TAPS_PER_PHASE = fsk4rrc_pkg::TAPS_PER_PHASE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample
    output logic        m_axis_tlast
);
    import fsk4rrc_pkg::*;

    t_grp_xfer                 push;
    t_grp_xfer                 head;
    logic                      q_full;
    logic                      pop;
    logic signed [SAMPLE_W-1:0] sample;

    // Request intake and symbol mapping
    fsk4rrc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_valid   (s_axis_tvalid),
        .o_s_ready   (s_axis_tready),
        .i_s_kind    (s_axis_tuser[0]),
        .i_s_byte    (s_axis_tdata),
        .i_q_full    (q_full),
        .o_push      (push)
    );

    // Decoupling queue
    fsk4rrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    // Interpolating filter
    fsk4rrc_filter #(
        .INTERP_FACTOR  (INTERP_FACTOR),
        .TAPS_PER_PHASE (TAPS_PER_PHASE)
    ) u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_m_sample (sample),
        .o_m_last   (m_axis_tlast)
    );

    assign m_axis_tdata = sample;

endmodule

/* tb/four_level_fsk_rrc_modulator_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for four_level_fsk_rrc_modulator: directed rows, then random phases.
// Depends on fsk4rrc_pkg and the modulator RTL; predicts every sample with its own RRC filter.
module four_level_fsk_rrc_modulator_tb;

    import fsk4rrc_pkg::*;

    localparam int NUM_PHASES      = 10;
    localparam int NUM_TAPS        = 9;
    localparam int SYMS_PER_REQ    = 4;
    localparam int SAMPLES_PER_REQ = SYMS_PER_REQ * NUM_PHASES;
    localparam int RRC_LEN         = NUM_PHASES * NUM_TAPS;
    localparam int NUM_DIRECTED    = 24;
    localparam int RANDOM_PHASES   = 5;
    localparam int REQS_PER_PHASE  = 88;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_GAP       = 8;
    localparam int TAIL_CYCLES     = 20;
    localparam int MAX_REPORTS     = 30;

    // RRC prototype in Q1.15, newest level meets the end of the table
    localparam logic signed [15:0] RRC_Q15 [RRC_LEN] = '{
        16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
        16'sd850, 16'sd592, 16'sd219, -16'sd234, -16'sd720, -16'sd1179,
        -16'sd1548, -16'sd1769, -16'sd1795, -16'sd1597,
        -16'sd1172, -16'sd544, 16'sd237, 16'sd1092, 16'sd1927, 16'sd2637,
        16'sd3120, 16'sd3286, 16'sd3073, 16'sd2454,
        16'sd1447, 16'sd116, -16'sd1431, -16'sd3043, -16'sd4544, -16'sd5739,
        -16'sd6442, -16'sd6483, -16'sd5735, -16'sd4121,
        -16'sd1633, 16'sd1669, 16'sd5651, 16'sd10118, 16'sd14822, 16'sd19485,
        16'sd23811, 16'sd27521, 16'sd30368, 16'sd32157,
        16'sd32767,
        16'sd32157, 16'sd30368, 16'sd27521, 16'sd23811, 16'sd19485, 16'sd14822,
        16'sd10118, 16'sd5651, 16'sd1669, -16'sd1633,
        -16'sd4121, -16'sd5735, -16'sd6483, -16'sd6442, -16'sd5739, -16'sd4544,
        -16'sd3043, -16'sd1431, 16'sd116, 16'sd1447,
        16'sd2454, 16'sd3073, 16'sd3286, 16'sd3120, 16'sd2637, 16'sd1927,
        16'sd1092, 16'sd237, -16'sd544, -16'sd1172,
        -16'sd1597, -16'sd1795, -16'sd1769, -16'sd1548, -16'sd1179, -16'sd720,
        -16'sd234, 16'sd219, 16'sd592, 16'sd850
    };

    // Symbol levels indexed by dibit value (C, D, B, A)
    localparam logic signed [15:0] LEVELS_HIGH [4] =
        '{-16'sd8258, -16'sd24805, 16'sd8258, 16'sd24805};
    localparam logic signed [15:0] LEVELS_LOW  [4] =
        '{-16'sd4129, -16'sd12419, 16'sd4129, 16'sd12419};

    typedef struct packed {
        logic signed [15:0] sample_val;
        logic               is_last;
    } t_sample;

    // One directed request; zero_out marks rows whose samples are all known zero
    typedef struct packed {
        logic       kind;
        logic [7:0] data_val;
        logic       dev;
        logic       zero_out;
    } t_stim_row;

    localparam t_stim_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{REQ_SILENCE, 8'hA5, 1'b0, 1'b1},   // silence right after reset: all zero
        '{REQ_DATA,    8'hFF, 1'b0, 1'b0},
        '{REQ_DATA,    8'h00, 1'b0, 1'b0},
        '{REQ_DATA,    8'h55, 1'b0, 1'b0},
        '{REQ_DATA,    8'hAA, 1'b0, 1'b0},
        '{REQ_DATA,    8'hE4, 1'b0, 1'b0},   // A B D C
        '{REQ_DATA,    8'h1B, 1'b0, 1'b0},   // C D B A
        '{REQ_SILENCE, 8'h3C, 1'b0, 1'b0},
        '{REQ_SILENCE, 8'hFF, 1'b0, 1'b0},
        '{REQ_SILENCE, 8'h00, 1'b0, 1'b1},   // history fully flushed: all zero
        '{REQ_DATA,    8'hCC, 1'b0, 1'b0},
        '{REQ_DATA,    8'h33, 1'b0, 1'b0},
        '{REQ_DATA,    8'hCC, 1'b0, 1'b0},
        '{REQ_DATA,    8'h33, 1'b0, 1'b0},
        '{REQ_DATA,    8'hFF, 1'b1, 1'b0},
        '{REQ_DATA,    8'h00, 1'b1, 1'b0},
        '{REQ_DATA,    8'h55, 1'b1, 1'b0},
        '{REQ_DATA,    8'hE4, 1'b1, 1'b0},
        '{REQ_SILENCE, 8'h5A, 1'b1, 1'b0},
        '{REQ_DATA,    8'h1B, 1'b1, 1'b0},
        '{REQ_DATA,    8'hAA, 1'b1, 1'b0},
        '{REQ_DATA,    8'hFF, 1'b0, 1'b0},
        '{REQ_SILENCE, 8'h81, 1'b0, 1'b0},
        '{REQ_DATA,    8'h96, 1'b0, 1'b0}
    };

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_wdata   = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic [0:0]  s_axis_tuser  = 1'b0;    // [0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [15:0] sample
    logic        m_axis_tlast;

    // Predictor state
    logic signed [15:0] level_hist [NUM_TAPS];
    logic               low_dev_model;
    t_sample            expected_samples [$];

    // Run control and bookkeeping
    logic sender_idling    = 1'b1;
    logic sink_idling      = 1'b1;
    logic hold_off_request = 1'b0;
    logic hold_off_active  = 1'b0;
    int   mismatch_count   = 0;
    int   requests_sent    = 0;
    int   silence_sent     = 0;
    int   samples_checked  = 0;
    int   cfg_writes       = 0;
    int   hold_offs_done   = 0;

    four_level_fsk_rrc_modulator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Polyphase output for phase ph of the newest level, rounded half up and saturated
    function automatic logic signed [15:0] phase_output(input int ph);
        longint acc;
        longint q;
        acc = 0;
        for (int k = 0; k < NUM_TAPS; k++) begin
            acc += longint'(level_hist[k]) * longint'(RRC_Q15[RRC_LEN - 1 - ph - k * NUM_PHASES]);
        end
        q = (acc + 64'sd32768) >>> 16;
        if (q > 32767) begin
            q = 32767;
        end else if (q < -32768) begin
            q = -32768;
        end
        return q[15:0];
    endfunction

    // Advance the symbol history by one request and queue its 40 samples
    task automatic modulate_request(input logic kind, input logic [7:0] data_val,
                                    input logic zero_known);
        logic [7:0]         dibits;
        logic signed [15:0] lvl;
        t_sample            s;
        int                 n;
        dibits = data_val;
        n = 0;
        for (int sym = 0; sym < SYMS_PER_REQ; sym++) begin
            if (kind == REQ_SILENCE) begin
                lvl = 16'sd0;
            end else begin
                lvl = low_dev_model ? LEVELS_LOW[dibits[7:6]] : LEVELS_HIGH[dibits[7:6]];
            end
            dibits = dibits << 2;
            for (int k = NUM_TAPS - 1; k > 0; k--) begin
                level_hist[k] = level_hist[k - 1];
            end
            level_hist[0] = lvl;
            for (int ph = 0; ph < NUM_PHASES; ph++) begin
                s.sample_val = zero_known ? 16'sd0 : phase_output(ph);
                s.is_last    = (n == SAMPLES_PER_REQ - 1);
                expected_samples.push_back(s);
                n++;
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("MISMATCH @%0t: %s", $time, what);
        end
    endtask

    // Compare one output transfer with the oldest expected sample
    task automatic check_sample();
        t_sample want;
        if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("unexpected sample %0d tlast %0b",
                                      $signed(m_axis_tdata), m_axis_tlast));
            return;
        end
        want = expected_samples.pop_front();
        samples_checked++;
        if (m_axis_tdata !== want.sample_val) begin
            report_mismatch($sformatf("sample %0d: got %0d, want %0d", samples_checked,
                                      $signed(m_axis_tdata), want.sample_val));
        end
        if (m_axis_tlast !== want.is_last) begin
            report_mismatch($sformatf("sample %0d: tlast got %0b, want %0b", samples_checked,
                                      m_axis_tlast, want.is_last));
        end
    endtask

    // Offer one request, idling first at random, and predict it on transfer
    task automatic offer_request(input logic kind, input logic [7:0] data_val,
                                 input logic zero_known);
        if (sender_idling && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data_val;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        modulate_request(kind, data_val, zero_known);
        requests_sent++;
        if (kind == REQ_SILENCE) begin
            silence_sent++;
        end
    endtask

    // Stop offering and wait until every expected sample has been checked
    task automatic drain_requests();
        s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_deviation(input logic dev);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= dev;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        low_dev_model = dev;
        cfg_writes++;
    endtask

    // Receiver: check transfers, then pick tready for the next edge
    initial begin : sample_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                check_sample();
            end
            if (hold_off_active) begin
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (sink_idling && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(1, 8) - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off, counted here so the sender keeps pushing meanwhile
    initial begin : receiver_hold_off
        forever begin
            wait (hold_off_request);
            @(posedge i_clk);
            hold_off_active <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            hold_off_active <= 1'b0;
            hold_off_request = 1'b0;
            hold_offs_done++;
        end
    end

    // Stimulus
    initial begin : stimulus
        logic       kind;
        logic [7:0] data_val;
        logic [7:0] last_data;
        int         silence_run;
        for (int k = 0; k < NUM_TAPS; k++) begin
            level_hist[k] = 16'sd0;
        end
        low_dev_model = 1'b0;
        last_data     = 8'h00;
        silence_run   = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_deviation(1'b0);

        // Directed rows; a deviation change waits for the block to go idle
        for (int r = 0; r < NUM_DIRECTED; r++) begin
            if (DIRECTED_ROWS[r].dev != low_dev_model) begin
                drain_requests();
                write_deviation(DIRECTED_ROWS[r].dev);
            end
            offer_request(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].data_val,
                          DIRECTED_ROWS[r].zero_out);
        end

        // Random phases, each under its own deviation setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_requests();
            if (p == 0) begin
                write_deviation(1'b1);
            end else if (p == 1) begin
                write_deviation(1'b0);
            end else begin
                write_deviation(1'($urandom_range(0, 1)));
            end
            sender_idling = (p != RANDOM_PHASES - 1);
            sink_idling   = (p != RANDOM_PHASES - 1);
            for (int i = 0; i < REQS_PER_PHASE; i++) begin
                if (p == 1 && i == 10) begin
                    hold_off_request = 1'b1;
                end
                kind     = REQ_DATA;
                data_val = 8'($urandom);
                if (silence_run > 0) begin
                    kind = REQ_SILENCE;
                    silence_run--;
                end else begin
                    case ($urandom_range(0, 9))
                        0: begin
                            kind        = REQ_SILENCE;
                            silence_run = $urandom_range(0, 3);
                        end
                        1: data_val = last_data;
                        2: begin
                            case ($urandom_range(0, 5))
                                0: data_val = 8'h00;
                                1: data_val = 8'hFF;
                                2: data_val = 8'h33;
                                3: data_val = 8'hCC;
                                4: data_val = 8'h55;
                                default: data_val = 8'hAA;
                            endcase
                        end
                        default: ;
                    endcase
                end
                if (kind == REQ_DATA) begin
                    last_data = data_val;
                end
                offer_request(kind, data_val, 1'b0);
            end
        end

        // Let everything drain, then allow for stray samples
        s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests (%0d silence), %0d samples checked, %0d deviation writes,",
                 requests_sent, silence_sent, samples_checked, cfg_writes);
        $display("both level sets, random handshake gaps and %0d long receiver hold-off(s).",
                 hold_offs_done);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #30_000_000;
        $display("Timeout: %0d samples still expected", expected_samples.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
